// ===== rtl/core/base64_stream_encoder_defines.svh =====
// Assertion macros of the base64 stream encoder RTL.
// Needs nothing else; included by base64_stream_encoder.sv, the file that carries assertions.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64SE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B64SE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/b64se_pkg.sv =====
// Package of the base64 stream encoder: beat types, state types and constants.
// Used by b64se_group_logic and base64_stream_encoder; depends on nothing.
`default_nettype none

package b64se_pkg;

	// Bytes per output line before a newline is inserted.
	localparam int LINE_BYTES = 57;
	localparam int LINE_CNT_W = 6;
	localparam int MAX_CHARS  = 5;
	localparam int CHAR_CNT_W = 3;

	localparam logic [7:0] PAD_CHAR = 8'd61;
	localparam logic [7:0] NL_CHAR  = 8'd10;

	// Position of the next byte within its 3-byte group.
	typedef enum logic [1:0] {
		PH_0 = 2'd0,
		PH_1 = 2'd1,
		PH_2 = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       encoded_end;
	} out_beat_t;

	typedef struct packed {
		phase_t                  phase;
		logic [3:0]              carry;
		logic [LINE_CNT_W-1:0]   line_cnt;
	} enc_state_t;

	// Characters produced by one byte, in emission order, plus the new state.
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [CHAR_CNT_W-1:0]     count;
		enc_state_t                next_state;
	} group_res_t;

	// Standard base64 alphabet lookup of one sextet.
	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'(8'd65 + {2'b00, v});
		end else if (v < 6'd52) begin
			r = 8'(8'd71 + {2'b00, v});
		end else if (v < 6'd62) begin
			r = 8'({2'b00, v} - 8'd4);
		end else if (v == 6'd62) begin
			r = 8'd43;
		end else begin
			r = 8'd47;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/base64_stream_encoder.sv =====
// Top level of the base64 stream encoder: input register, character buffer, state.
// Depends on b64se_pkg, b64se_group_logic and base64_stream_encoder_defines.svh.
//
// Streaming base64 encoder (standard alphabet, '=' padding, optional newline
// after every 57 bytes and at message end). Bytes enter on the byte channel one
// beat at a time with an end-of-message flag; characters leave on the char
// channel, one beat per cycle while char_stall is low, flagged with run_last
// on the last character of each byte and encoded_end on the final character
// of the message. Each byte occupies the character buffer until all of its
// characters, one to five, have left, so a byte can be taken every cycle when
// each yields one character and char_stall stays low; long messages sustain
// four characters per three bytes (77 characters per 57 bytes with wrapping
// on). The one-character-per-cycle output port bounds the byte rate. The input
// register takes the next byte while the buffer still drains the previous one.
// wrap_enable is written on the cfg channel, which is always ready; write it
// only while no message is in flight.
`default_nettype none

`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder
	import b64se_pkg::*;
(
	input  var logic      clk,
	input  var logic      arst_n,
	input  var logic      byte_valid,
	output logic          byte_stall,
	input  var in_beat_t  byte_data,
	output logic          char_valid,
	input  var logic      char_stall,
	output out_beat_t     char_data,
	input  var logic      cfg_valid,
	output logic          cfg_ready,
	input  var logic      cfg_data
);

	logic                      wrap_q;
	enc_state_t                state_q;
	logic                      in_valid_s1;
	in_beat_t                  in_s1;
	logic                      buf_valid_s2;
	logic [MAX_CHARS-1:0][7:0] chars_s2;
	logic [CHAR_CNT_W-1:0]     count_s2;
	logic [CHAR_CNT_W-1:0]     idx_s2;
	logic                      end_s2;
	group_res_t                res;
	logic                      in_take;
	logic                      out_take;
	logic                      is_last_char;
	logic                      buf_free;
	logic                      move;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			wrap_q <= cfg_data;
		end
	end

	// Handshake decisions.
	assign is_last_char = (idx_s2 == CHAR_CNT_W'(count_s2 - 1'b1));
	assign out_take     = char_valid && !char_stall;
	assign buf_free     = out_take && is_last_char;
	assign move         = in_valid_s1 && (!buf_valid_s2 || buf_free);
	assign byte_stall   = in_valid_s1 && !move;
	assign in_take      = byte_valid && !byte_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_take) begin
			in_valid_s1 <= 1'b1;
		end else if (move) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			in_s1 <= byte_data;
		end
	end

	// Encoding of the registered byte.
	b64se_group_logic u_group (
		.beat      (in_s1),
		.wrap_en   (wrap_q),
		.cur_state (state_q),
		.res       (res)
	);

	// Encoder state advances when a byte moves into the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_0;
			state_q.carry    <= '0;
			state_q.line_cnt <= '0;
		end else if (move) begin
			state_q <= res.next_state;
		end
	end

	// Character buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_s2 <= 1'b0;
			idx_s2       <= '0;
		end else if (move) begin
			buf_valid_s2 <= 1'b1;
			idx_s2       <= '0;
		end else if (buf_free) begin
			buf_valid_s2 <= 1'b0;
		end else if (out_take) begin
			idx_s2 <= CHAR_CNT_W'(idx_s2 + 1'b1);
		end
	end

	// Character buffer payload.
	always_ff @(posedge clk) begin
		if (move) begin
			chars_s2 <= res.chars;
			count_s2 <= res.count;
			end_s2   <= in_s1.message_end;
		end
	end

	// Output beat.
	assign char_valid            = buf_valid_s2;
	assign char_data.out_char    = chars_s2[idx_s2];
	assign char_data.run_last    = is_last_char;
	assign char_data.encoded_end = is_last_char && end_s2;

	// Assertions.
	`B64SE_ASSERT_SAME(a_idx_in_range, clk, arst_n, buf_valid_s2, idx_s2 < count_s2,
		"character index beyond buffer count")
	`B64SE_ASSERT_NEXT(a_drain_step, clk, arst_n, out_take && !is_last_char,
		char_valid && (idx_s2 == CHAR_CNT_W'($past(idx_s2) + 1'b1)),
		"buffer did not advance to next character")
	`B64SE_ASSERT_SAME(a_end_is_last, clk, arst_n, char_valid && char_data.encoded_end,
		char_data.run_last, "message end flagged on a non-final character")
	`B64SE_ASSERT_NEXT(a_msg_end_clears, clk, arst_n, move && in_s1.message_end,
		(state_q.phase == PH_0) && (state_q.carry == '0) && (state_q.line_cnt == '0),
		"state not cleared after message end")

endmodule

`default_nettype wire

// ===== rtl/core/b64se_group_logic.sv =====
// Combinational encoding of one message byte into up to five characters.
// Depends on b64se_pkg; instantiated by base64_stream_encoder.
`default_nettype none

module b64se_group_logic
	import b64se_pkg::*;
(
	input  var in_beat_t   beat,
	input  var logic       wrap_en,
	input  var enc_state_t cur_state,
	output group_res_t     res
);

	logic [7:0]              b;
	logic                    last;
	logic [LINE_CNT_W:0]     cnt_inc;
	logic [LINE_CNT_W-1:0]   cnt_next;
	logic [MAX_CHARS-1:0][7:0] chars;
	logic [CHAR_CNT_W-1:0]   n;
	enc_state_t              nxt;

	assign b    = beat.data_byte;
	assign last = beat.message_end;

	// Line byte counter wraps to zero at the end of each line span.
	always_comb begin
		cnt_inc = (LINE_CNT_W+1)'({1'b0, cur_state.line_cnt} + 1'b1);
		if (cnt_inc >= (LINE_CNT_W+1)'(LINE_BYTES)) begin
			cnt_next = '0;
		end else begin
			cnt_next = cnt_inc[LINE_CNT_W-1:0];
		end
	end

	// Build the character list and the next state for this byte.
	always_comb begin
		chars = '0;
		n     = '0;
		nxt   = cur_state;
		case (cur_state.phase)
			PH_1: begin
				chars[0] = sextet_char({cur_state.carry[1:0], b[7:4]});
				nxt.phase = PH_2;
				nxt.carry = b[3:0];
				n = CHAR_CNT_W'(1);
				if (last) begin
					chars[1] = sextet_char({b[3:0], 2'b00});
					chars[2] = PAD_CHAR;
					n = CHAR_CNT_W'(3);
				end
			end
			PH_2: begin
				chars[0] = sextet_char({cur_state.carry[3:0], b[7:6]});
				chars[1] = sextet_char(b[5:0]);
				nxt.phase = PH_0;
				nxt.carry = '0;
				n = CHAR_CNT_W'(2);
				if (wrap_en && (cnt_next == '0)) begin
					chars[2] = NL_CHAR;
					n = CHAR_CNT_W'(3);
				end
			end
			default: begin
				// Phase zero; an unused phase code behaves the same way.
				chars[0] = sextet_char(b[7:2]);
				nxt.phase = PH_1;
				nxt.carry = {2'b00, b[1:0]};
				n = CHAR_CNT_W'(1);
				if (last) begin
					chars[1] = sextet_char({b[1:0], 4'b0000});
					chars[2] = PAD_CHAR;
					chars[3] = PAD_CHAR;
					n = CHAR_CNT_W'(4);
				end
			end
		endcase
		nxt.line_cnt = cnt_next;

		// Message end: final newline when wrapping, then back to a clean state.
		if (last) begin
			if (wrap_en) begin
				chars[n] = NL_CHAR;
				n = CHAR_CNT_W'(n + 1'b1);
			end
			nxt.phase    = PH_0;
			nxt.carry    = '0;
			nxt.line_cnt = '0;
		end
	end

	assign res.chars      = chars;
	assign res.count      = n;
	assign res.next_state = nxt;

endmodule

`default_nettype wire
